>>> rtl/aaq_pkg.sv
// ----------------------------------------------------------------------------
// aaq_pkg
// Shared types, widths, constants and tables of the axis-angle to quaternion
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aaq_pkg;

  // Default build parameters.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRACTION_BITS_DEF = 14;

  // Fixed step counts of the square root and the reciprocal chains.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 47;

  // Datapath widths.
  localparam int M_W   = 64;  // square root radicand and partial root
  localparam int S_W   = 32;  // square root result
  localparam int Q_W   = 47;  // reciprocal quotient
  localparam int CZ_W  = 34;  // CORDIC angle accumulator, Q2.30
  localparam int CXY_W = 34;  // CORDIC vector components, Q2.30
  localparam int PRD_W = 67;  // final product before rounding

  // Q2.30 constants.
  localparam logic signed [CXY_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [34:0]      PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0]      HALF_PI_Q30 = 35'sd1686629713;

  // Remainder that the reciprocal chain starts from: the top bits of 2^62.
  localparam logic [S_W-1:0] DIV_REM_INIT = 32'h0000_8000;

  // Side payload that travels with each item along the chain.
  typedef struct packed {
    logic signed [15:0]      ax_x;
    logic signed [15:0]      ax_y;
    logic signed [15:0]      ax_z;
    logic signed [CZ_W-1:0]  cz;
    logic                    neg;
    logic                    zero;
  } side_t;

  // Arctangent of 2^-idx in Q2.30, truncated.
  function automatic logic signed [CZ_W-1:0] atan_q30(input int idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic [15:0] sat16(input logic signed [PRD_W-1:0] v);
    logic [15:0] r;
    if (v > 67'sd32767) begin
      r = 16'h7fff;
    end else if (v < -67'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/axis_angle_to_quaternion.sv
// ----------------------------------------------------------------------------
// axis_angle_to_quaternion
// Turns a rotation angle and an axis of any length into a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_angle, in_axis_x/y/z) is taken at each rising edge where start
//   is high and busy is low. busy stays low: the block is a pipeline and takes
//   one item every cycle.
//   The result (out_quat_w/x/y/z, out_zero_axis) is shown for one cycle with
//   out_valid high. Results leave in input order.
//   The chain of cells is: one input stage, 32 square root cells, 47
//   reciprocal cells, CORDIC_STAGES rotation cells and five output stages with
//   the multipliers.
//   An axis of all zeros gives a quaternion of zeros and out_zero_axis high.
//   Reset clears every valid flag in the chain, so no result leaves until an
//   item has passed through. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_to_quaternion #(
  parameter int CORDIC_STAGES = aaq_pkg::CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = aaq_pkg::FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [16:0] in_angle,
  input  wire logic signed [15:0] in_axis_x,
  input  wire logic signed [15:0] in_axis_y,
  input  wire logic signed [15:0] in_axis_z,
  output logic                    out_valid,
  output logic signed [15:0]      out_quat_w,
  output logic signed [15:0]      out_quat_x,
  output logic signed [15:0]      out_quat_y,
  output logic signed [15:0]      out_quat_z,
  output logic                    out_zero_axis
);

  localparam int NSQ = aaq_pkg::SQRT_STEPS;
  localparam int NDV = aaq_pkg::DIV_STEPS;

  logic                     s0_valid_r;
  aaq_pkg::side_t           s0_side_r, s0_side_nxt;
  logic [aaq_pkg::M_W-1:0]  s0_m_r;
  logic [31:0]              norm_sq;
  logic signed [34:0]       cz_raw;

  logic                     sq_valid [NSQ+1];
  aaq_pkg::side_t           sq_side  [NSQ+1];
  logic [aaq_pkg::M_W-1:0]  sq_m     [NSQ+1];
  logic [aaq_pkg::M_W-1:0]  sq_res   [NSQ+1];

  logic                     dv_valid [NDV+1];
  aaq_pkg::side_t           dv_side  [NDV+1];
  logic [aaq_pkg::S_W-1:0]  dv_s     [NDV+1];
  logic [aaq_pkg::S_W-1:0]  dv_rem   [NDV+1];
  logic [aaq_pkg::Q_W-1:0]  dv_q     [NDV+1];

  logic                              cr_valid [CORDIC_STAGES+1];
  aaq_pkg::side_t                    cr_side  [CORDIC_STAGES+1];
  logic [aaq_pkg::Q_W-1:0]           cr_inv   [CORDIC_STAGES+1];
  logic signed [aaq_pkg::CXY_W-1:0]  cr_cx    [CORDIC_STAGES+1];
  logic signed [aaq_pkg::CXY_W-1:0]  cr_cy    [CORDIC_STAGES+1];

  assign busy = 1'b0;

  // Input stage: squared length of the axis and the folded half angle.
  always_comb begin
    norm_sq = 32'(32'(in_axis_x * in_axis_x) + 32'(in_axis_y * in_axis_y)
                  + 32'(in_axis_z * in_axis_z));
    cz_raw  = {{2{in_angle[16]}}, in_angle, 16'b0};
    s0_side_nxt.ax_x = in_axis_x;
    s0_side_nxt.ax_y = in_axis_y;
    s0_side_nxt.ax_z = in_axis_z;
    s0_side_nxt.zero = (norm_sq == 32'd0);
    if (cz_raw > aaq_pkg::HALF_PI_Q30) begin
      s0_side_nxt.cz  = aaq_pkg::CZ_W'(cz_raw - aaq_pkg::PI_Q30);
      s0_side_nxt.neg = 1'b1;
    end else if (cz_raw < -aaq_pkg::HALF_PI_Q30) begin
      s0_side_nxt.cz  = aaq_pkg::CZ_W'(cz_raw + aaq_pkg::PI_Q30);
      s0_side_nxt.neg = 1'b1;
    end else begin
      s0_side_nxt.cz  = aaq_pkg::CZ_W'(cz_raw);
      s0_side_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r <= s0_side_nxt;
    s0_m_r    <= {norm_sq, 32'b0};
  end

  // Square root chain.
  assign sq_valid[0] = s0_valid_r;
  assign sq_side[0]  = s0_side_r;
  assign sq_m[0]     = s0_m_r;
  assign sq_res[0]   = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    aaq_sqrt_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_valid[k]),
      .side_i  (sq_side[k]),
      .m_i     (sq_m[k]),
      .res_i   (sq_res[k]),
      .valid_o (sq_valid[k+1]),
      .side_o  (sq_side[k+1]),
      .m_o     (sq_m[k+1]),
      .res_o   (sq_res[k+1])
    );
  end

  // Reciprocal chain.
  assign dv_valid[0] = sq_valid[NSQ];
  assign dv_side[0]  = sq_side[NSQ];
  assign dv_s[0]     = sq_res[NSQ][aaq_pkg::S_W-1:0];
  assign dv_rem[0]   = aaq_pkg::DIV_REM_INIT;
  assign dv_q[0]     = '0;

  for (genvar k = 0; k < NDV; k++) begin : g_div
    aaq_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_valid[k]),
      .side_i  (dv_side[k]),
      .s_i     (dv_s[k]),
      .rem_i   (dv_rem[k]),
      .q_i     (dv_q[k]),
      .valid_o (dv_valid[k+1]),
      .side_o  (dv_side[k+1]),
      .s_o     (dv_s[k+1]),
      .rem_o   (dv_rem[k+1]),
      .q_o     (dv_q[k+1])
    );
  end

  // CORDIC chain for the sine and cosine of the half angle.
  assign cr_valid[0] = dv_valid[NDV];
  assign cr_side[0]  = dv_side[NDV];
  assign cr_inv[0]   = dv_q[NDV];
  assign cr_cx[0]    = aaq_pkg::GAIN_Q30;
  assign cr_cy[0]    = '0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    aaq_cordic_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cr_valid[k]),
      .side_i  (cr_side[k]),
      .inv_i   (cr_inv[k]),
      .cx_i    (cr_cx[k]),
      .cy_i    (cr_cy[k]),
      .valid_o (cr_valid[k+1]),
      .side_o  (cr_side[k+1]),
      .inv_o   (cr_inv[k+1]),
      .cx_o    (cr_cx[k+1]),
      .cy_o    (cr_cy[k+1])
    );
  end

  // Output stages.
  aaq_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (cr_valid[CORDIC_STAGES]),
    .side_i        (cr_side[CORDIC_STAGES]),
    .inv_i         (cr_inv[CORDIC_STAGES]),
    .cx_i          (cr_cx[CORDIC_STAGES]),
    .cy_i          (cr_cy[CORDIC_STAGES]),
    .out_valid     (out_valid),
    .out_quat_w    (out_quat_w),
    .out_quat_x    (out_quat_x),
    .out_quat_y    (out_quat_y),
    .out_quat_z    (out_quat_z),
    .out_zero_axis (out_zero_axis)
  );

endmodule

`default_nettype wire

>>> rtl/aaq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aaq_sqrt_cell
// One step of the bitwise integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aaq_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_i,
  input  wire aaq_pkg::side_t             side_i,
  input  wire logic [aaq_pkg::M_W-1:0]    m_i,
  input  wire logic [aaq_pkg::M_W-1:0]    res_i,
  output logic                            valid_o,
  output aaq_pkg::side_t                  side_o,
  output logic [aaq_pkg::M_W-1:0]         m_o,
  output logic [aaq_pkg::M_W-1:0]         res_o
);

  localparam logic [aaq_pkg::M_W-1:0] BIT = aaq_pkg::M_W'(1) << (62 - 2 * STEP);

  logic                      valid_r;
  aaq_pkg::side_t            side_r;
  logic [aaq_pkg::M_W-1:0]   m_r, m_nxt;
  logic [aaq_pkg::M_W-1:0]   res_r, res_nxt;
  logic [aaq_pkg::M_W-1:0]   trial;

  // Try the next root bit against the remaining radicand.
  always_comb begin
    trial = res_i + BIT;
    if (m_i >= trial) begin
      m_nxt   = m_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      m_nxt   = m_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    m_r    <= m_nxt;
    res_r  <= res_nxt;
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign m_o     = m_r;
  assign res_o   = res_r;

endmodule

`default_nettype wire

>>> rtl/aaq_div_cell.sv
// ----------------------------------------------------------------------------
// aaq_div_cell
// One quotient bit of the restoring division 2^62 / s, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aaq_div_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_i,
  input  wire aaq_pkg::side_t             side_i,
  input  wire logic [aaq_pkg::S_W-1:0]    s_i,
  input  wire logic [aaq_pkg::S_W-1:0]    rem_i,
  input  wire logic [aaq_pkg::Q_W-1:0]    q_i,
  output logic                            valid_o,
  output aaq_pkg::side_t                  side_o,
  output logic [aaq_pkg::S_W-1:0]         s_o,
  output logic [aaq_pkg::S_W-1:0]         rem_o,
  output logic [aaq_pkg::Q_W-1:0]         q_o
);

  logic                      valid_r;
  aaq_pkg::side_t            side_r;
  logic [aaq_pkg::S_W-1:0]   s_r;
  logic [aaq_pkg::S_W-1:0]   rem_r, rem_nxt;
  logic [aaq_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [aaq_pkg::S_W:0]     rem_sh;
  logic [aaq_pkg::S_W:0]     diff;

  // Shift in a zero dividend bit and subtract the divisor where it fits.
  always_comb begin
    rem_sh = {rem_i, 1'b0};
    diff   = rem_sh - {1'b0, s_i};
    if (rem_sh >= {1'b0, s_i}) begin
      rem_nxt = diff[aaq_pkg::S_W-1:0];
      q_nxt   = {q_i[aaq_pkg::Q_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[aaq_pkg::S_W-1:0];
      q_nxt   = {q_i[aaq_pkg::Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    s_r    <= s_i;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign s_o     = s_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;

endmodule

`default_nettype wire

>>> rtl/aaq_cordic_cell.sv
// ----------------------------------------------------------------------------
// aaq_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aaq_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              valid_i,
  input  wire aaq_pkg::side_t                    side_i,
  input  wire logic [aaq_pkg::Q_W-1:0]           inv_i,
  input  wire logic signed [aaq_pkg::CXY_W-1:0]  cx_i,
  input  wire logic signed [aaq_pkg::CXY_W-1:0]  cy_i,
  output logic                                   valid_o,
  output aaq_pkg::side_t                         side_o,
  output logic [aaq_pkg::Q_W-1:0]                inv_o,
  output logic signed [aaq_pkg::CXY_W-1:0]       cx_o,
  output logic signed [aaq_pkg::CXY_W-1:0]       cy_o
);

  localparam logic signed [aaq_pkg::CZ_W-1:0] ATAN = aaq_pkg::atan_q30(IDX);

  logic                                 valid_r;
  aaq_pkg::side_t                       side_r, side_nxt;
  logic [aaq_pkg::Q_W-1:0]              inv_r;
  logic signed [aaq_pkg::CXY_W-1:0]     cx_r, cx_nxt;
  logic signed [aaq_pkg::CXY_W-1:0]     cy_r, cy_nxt;
  logic signed [aaq_pkg::CXY_W-1:0]     dx, dy;

  // Rotate towards a zero residual angle.
  always_comb begin
    dx       = cy_i >>> IDX;
    dy       = cx_i >>> IDX;
    side_nxt = side_i;
    if (side_i.cz >= 0) begin
      cx_nxt      = cx_i - dx;
      cy_nxt      = cy_i + dy;
      side_nxt.cz = side_i.cz - ATAN;
    end else begin
      cx_nxt      = cx_i + dx;
      cy_nxt      = cy_i - dy;
      side_nxt.cz = side_i.cz + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    inv_r  <= inv_i;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign inv_o   = inv_r;
  assign cx_o    = cx_r;
  assign cy_o    = cy_r;

endmodule

`default_nettype wire

>>> rtl/aaq_scale.sv
// ----------------------------------------------------------------------------
// aaq_scale
// Output stages: unit axis, products with the sine, scaled cosine, rounding and
// saturation to Q1.F.
// ----------------------------------------------------------------------------
`default_nettype none

module aaq_scale #(
  parameter int FRACTION_BITS = aaq_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              valid_i,
  input  wire aaq_pkg::side_t                    side_i,
  input  wire logic [aaq_pkg::Q_W-1:0]           inv_i,
  input  wire logic signed [aaq_pkg::CXY_W-1:0]  cx_i,
  input  wire logic signed [aaq_pkg::CXY_W-1:0]  cy_i,
  output logic                                   out_valid,
  output logic signed [15:0]                     out_quat_w,
  output logic signed [15:0]                     out_quat_x,
  output logic signed [15:0]                     out_quat_y,
  output logic signed [15:0]                     out_quat_z,
  output logic                                   out_zero_axis
);

  localparam int K_W = 30 - FRACTION_BITS;
  localparam int K_X = 60 - FRACTION_BITS;
  localparam logic signed [34:0] HALF_W = 35'sd1 <<< K_W >>> 1;
  localparam logic signed [aaq_pkg::PRD_W-1:0] HALF_X =
    (aaq_pkg::PRD_W'(1) << K_X) >> 1;

  logic [4:0] valid_r;
  logic [3:0] zero_r;

  logic signed [15:0]               ax [3];
  logic signed [aaq_pkg::CXY_W-1:0] cs1_r, sn1_r;
  logic signed [40:0]               plo1_r [3];
  logic signed [39:0]               phi1_r [3];
  logic signed [aaq_pkg::CXY_W-1:0] cs2_r, sn2_r;
  logic signed [31:0]               u2_r [3];
  logic signed [34:0]               w3_r;
  logic signed [49:0]               pl3_r [3];
  logic signed [48:0]               ph3_r [3];
  logic signed [34:0]               w4_r;
  logic signed [aaq_pkg::PRD_W-1:0] p4_r [3];
  logic signed [63:0]               uprod [3];
  logic signed [aaq_pkg::PRD_W-1:0] wsh;
  logic [15:0]                      q_nxt [3];

  assign ax[0] = side_i.ax_x;
  assign ax[1] = side_i.ax_y;
  assign ax[2] = side_i.ax_z;

  // Valid and zero-axis flags follow the item down the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= {zero_r[2:0], side_i.zero};
  end

  // Stage 1: undo the quadrant fold; axis times reciprocal in two halves.
  always_ff @(posedge clk) begin
    cs1_r <= side_i.neg ? -cx_i : cx_i;
    sn1_r <= side_i.neg ? -cy_i : cy_i;
    for (int i = 0; i < 3; i++) begin
      plo1_r[i] <= ax[i] * $signed({1'b0, inv_i[23:0]});
      phi1_r[i] <= ax[i] * $signed({1'b0, inv_i[aaq_pkg::Q_W-1:24]});
    end
  end

  // Stage 2: join the halves into the unit axis component, Q2.30.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uprod[i] = ((64'(phi1_r[i]) <<< 24) + 64'(plo1_r[i])) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    cs2_r <= cs1_r;
    sn2_r <= sn1_r;
    for (int i = 0; i < 3; i++) begin
      u2_r[i] <= uprod[i][31:0];
    end
  end

  // Stage 3: unit axis times sine, sine split in two halves; cosine plus rounding constant.
  always_ff @(posedge clk) begin
    w3_r <= 35'(cs2_r) + HALF_W;
    for (int i = 0; i < 3; i++) begin
      pl3_r[i] <= u2_r[i] * $signed({1'b0, sn2_r[16:0]});
      ph3_r[i] <= u2_r[i] * $signed(sn2_r[aaq_pkg::CXY_W-1:17]);
    end
  end

  // Stage 4: join the halves and add the rounding constant.
  always_ff @(posedge clk) begin
    w4_r <= w3_r;
    for (int i = 0; i < 3; i++) begin
      p4_r[i] <= (aaq_pkg::PRD_W'(ph3_r[i]) <<< 17) + aaq_pkg::PRD_W'(pl3_r[i]) + HALF_X;
    end
  end

  // Stage 5: scale down, saturate and register the result item.
  always_comb begin
    wsh = aaq_pkg::PRD_W'(w4_r >>> K_W);
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = aaq_pkg::sat16(p4_r[i] >>> K_X);
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[3]) begin
      out_quat_w <= '0;
      out_quat_x <= '0;
      out_quat_y <= '0;
      out_quat_z <= '0;
    end else begin
      out_quat_w <= aaq_pkg::sat16(wsh);
      out_quat_x <= q_nxt[0];
      out_quat_y <= q_nxt[1];
      out_quat_z <= q_nxt[2];
    end
    out_zero_axis <= zero_r[3];
  end

  assign out_valid = valid_r[4];

endmodule

`default_nettype wire
